[hw/rtl/utbd_pkg.sv]
// Package for the unsigned-to-digits converter: widths, radix bounds,
// ASCII mapping and the sequencer state type. No dependencies.
`default_nettype none

package utbd_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int IN_VALUE_W     = 64;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int COUNT_W        = 7;
	localparam int CHUNK_W        = 8;
	localparam int S_DATA_W       = 72;
	localparam int M_DATA_W       = 16;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = CHAR_A + {1'b0, d} - {1'b0, DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/utbd_div_step.sv]
// Shared divide unit: combinationally divides an eight-bit chunk, extended by
// the running remainder, by the radix. Depends on utbd_pkg.
`default_nettype none

module utbd_div_step
	import utbd_pkg::*;
(
	input  wire logic [RADIX_W-1:0] rem_in,
	input  wire logic [CHUNK_W-1:0] chunk,
	input  wire logic [RADIX_W-1:0] radix,
	output logic      [CHUNK_W-1:0] quo,
	output logic      [RADIX_W-1:0] rem_out
);

	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [RADIX_W:0]   t;
		r = rem_in;
		quo = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= {1'b0, radix}) begin
				t = t - {1'b0, radix};
				quo[i] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		rem_out = r;
	end

endmodule

`default_nettype wire

[hw/rtl/utbd_digit_ram.sv]
// Digit store: one write port and one registered read port, holding the
// ASCII digits of a conversion in the order they are found. Depends on utbd_pkg.
`default_nettype none

module utbd_digit_ram
	import utbd_pkg::*;
#(
	parameter int DEPTH  = VALUE_BITS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [CHAR_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [CHAR_W-1:0] rd_data
);

	logic [CHAR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/unsigned_to_base_digits.sv]
// Sequence: accept into idle, then each digit is found by passing every eight-bit
// chunk of the value through the shared divide unit, then each emitted digit goes
// through a memory read and an output state, which can stall on m_tready;
// one transaction is in work at a time, s_tready only when idle.
// Reset (arst_n low, asynchronous) returns the sequencer to idle with no
// output pending; the digit store needs no clearing.
// Top level of the converter; depends on utbd_pkg, utbd_div_step, utbd_digit_ram.
`default_nettype none

module unsigned_to_base_digits
	import utbd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// Fields from bit 0: value[63:0], radix[69:64], zero pad.
	input  wire logic [S_DATA_W-1:0] s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// Fields from bit 0: digit_char[6:0], digit_count[13:7], zero pad.
	output logic      [M_DATA_W-1:0] m_tdata,
	output logic                     m_tlast
);

	localparam int CHUNKS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int DIV_W  = CHUNKS * CHUNK_W;
	localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int ADDR_W = $clog2(VALUE_BITS);

	state_t             state_q;
	logic [DIV_W-1:0]   val_q;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] rem_q;
	logic               qnz_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0] n_q;
	logic [ADDR_W-1:0]  idx_q;

	logic [CHUNK_W-1:0]       quo;
	logic [RADIX_W-1:0]       rem_next;
	logic [DIV_W+CHUNK_W-1:0] val_shift;
	logic [RADIX_W-1:0]       radix_in;
	logic                     last_chunk;
	logic                     more;
	logic [COUNT_W-1:0]       n_next;
	logic                     wr_en;
	logic [CHAR_W-1:0]        rd_data;
	logic                     s_fire;
	logic                     m_fire;

	utbd_div_step u_div (
		.rem_in  (rem_q),
		.chunk   (val_q[DIV_W-1 -: CHUNK_W]),
		.radix   (radix_q),
		.quo     (quo),
		.rem_out (rem_next)
	);

	utbd_digit_ram #(
		.DEPTH  (VALUE_BITS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (n_q[ADDR_W-1:0]),
		.wr_data (digit_to_char(rem_next)),
		.rd_en   (state_q == ST_RD),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		logic [RADIX_W-1:0] r;
		r = s_tdata[IN_VALUE_W +: RADIX_W];
		if (r < RADIX_MIN) begin
			radix_in = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			radix_in = RADIX_MAX;
		end else begin
			radix_in = r;
		end
	end

	assign val_shift  = {val_q, quo};
	assign last_chunk = (cnt_q == CNT_W'(CHUNKS - 1));
	assign n_next     = n_q + COUNT_W'(1);
	assign more       = (qnz_q || (quo != '0)) && (n_next != COUNT_W'(VALUE_BITS));
	assign wr_en      = (state_q == ST_DIV) && last_chunk;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {{(M_DATA_W - COUNT_W - CHAR_W){1'b0}}, n_q, rd_data};
	assign m_tlast  = (idx_q == '0);
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						n_q     <= '0;
					end
				end
				ST_DIV: begin
					if (last_chunk) begin
						cnt_q <= '0;
						n_q   <= n_next;
						if (!more) begin
							idx_q   <= n_q[ADDR_W-1:0];
							state_q <= ST_RD;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_fire) begin
						if (m_tlast) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q - ADDR_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			val_q   <= DIV_W'(s_tdata[VALUE_BITS-1:0]);
			radix_q <= radix_in;
			rem_q   <= '0;
			qnz_q   <= 1'b0;
		end else if (state_q == ST_DIV) begin
			val_q <= val_shift[DIV_W-1:0];
			if (last_chunk) begin
				rem_q <= '0;
				qnz_q <= 1'b0;
			end else begin
				rem_q <= rem_next;
				qnz_q <= qnz_q || (quo != '0);
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_DIV) && (n_q == '0))
		else $error("accepted transaction did not start a fresh division");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (n_q != '0) && (n_q <= COUNT_W'(VALUE_BITS)))
		else $error("digit count out of range on output");

	a_next_digit_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && !m_tlast |=> !m_tvalid && (state_q == ST_RD))
		else $error("next digit not fetched after output transaction");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && m_tlast |=> s_tready && !m_tvalid)
		else $error("block not idle after last digit");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, idx_q} < n_q))
		else $error("digit index beyond digit count");

endmodule

`default_nettype wire
